>>> hw/rtl/btbp_pkg.sv
// ----------------------------------------------------------------------------
// btbp_pkg
// Shared types and constants for the branch target buffer predictor.
// ----------------------------------------------------------------------------
package btbp_pkg;

    // default table depth, must be a power of two
    localparam int TABLE_ENTRIES_DEF = 1024;

    // index is taken from the address starting at this bit
    localparam int INDEX_SHIFT = 10;

    // fixed instruction size for the fall-through address
    localparam logic [31:0] INSN_BYTES = 32'd4;

    localparam int ADDR_W  = 32;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 168;

    // two-bit direction states
    localparam logic [1:0] PRED_STRONG_TAKEN     = 2'b00;
    localparam logic [1:0] PRED_WEAK_TAKEN       = 2'b01;
    localparam logic [1:0] PRED_WEAK_NOT_TAKEN   = 2'b10;
    localparam logic [1:0] PRED_STRONG_NOT_TAKEN = 2'b11;

    // one table entry as stored in memory
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] target;
        logic [1:0]        pred;
    } t_entry;

    // outcome of one lookup
    typedef struct packed {
        logic wr_en;
        logic hit;
        logic right;
        logic alloc;
        logic coll;
    } t_upd;

endpackage

>>> hw/rtl/btbp_table.sv
// ----------------------------------------------------------------------------
// btbp_table
// Direct-mapped entry memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module btbp_table #(
    parameter int TABLE_ENTRIES = btbp_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [IDX_W-1:0]    i_rd_addr,
    output btbp_pkg::t_entry    o_rd_data,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  btbp_pkg::t_entry    i_wr_data
);

    btbp_pkg::t_entry r_mem [TABLE_ENTRIES];
    btbp_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/btbp_update.sv
// ----------------------------------------------------------------------------
// btbp_update
// Scores one lookup against its entry and forms the entry to write back.
// ----------------------------------------------------------------------------
module btbp_update (
    input  logic [btbp_pkg::ADDR_W-1:0] i_pc,
    input  logic [btbp_pkg::ADDR_W-1:0] i_next_pc,
    input  btbp_pkg::t_entry            i_entry,
    output btbp_pkg::t_entry            o_entry,
    output btbp_pkg::t_upd              o_upd
);

    logic taken;
    logic hit;

    assign taken = (i_next_pc != (i_pc + btbp_pkg::INSN_BYTES));
    assign hit   = i_entry.valid && (i_entry.tag == i_pc);

    // train on a hit, allocate on a taken miss
    always_comb begin
        o_entry     = i_entry;
        o_upd       = '0;
        o_upd.hit   = hit;
        if (hit) begin
            o_upd.wr_en = 1'b1;
            if (taken) begin
                if (!i_entry.pred[1]) begin
                    if (i_entry.target == i_next_pc) begin
                        o_upd.right  = 1'b1;
                        o_entry.pred = btbp_pkg::PRED_STRONG_TAKEN;
                    end else begin
                        o_entry.target = i_next_pc;
                    end
                end else begin
                    o_entry.pred = i_entry.pred - 2'd1;
                end
            end else begin
                case (i_entry.pred)
                    btbp_pkg::PRED_STRONG_TAKEN: begin
                        o_entry.pred = btbp_pkg::PRED_WEAK_TAKEN;
                    end
                    btbp_pkg::PRED_WEAK_TAKEN: begin
                        o_entry.pred = btbp_pkg::PRED_WEAK_NOT_TAKEN;
                    end
                    default: begin
                        o_upd.right  = 1'b1;
                        o_entry.pred = btbp_pkg::PRED_STRONG_NOT_TAKEN;
                    end
                endcase
            end
        end else if (taken) begin
            o_upd.wr_en    = 1'b1;
            o_upd.alloc    = 1'b1;
            o_upd.coll     = i_entry.valid;
            o_entry.valid  = 1'b1;
            o_entry.tag    = i_pc;
            o_entry.target = i_next_pc;
            o_entry.pred   = btbp_pkg::PRED_STRONG_TAKEN;
        end
    end

endmodule

>>> hw/rtl/branch_target_buffer_predictor.sv
// ----------------------------------------------------------------------------
// branch_target_buffer_predictor
// Direct-mapped branch target buffer with two-bit direction prediction.
// ----------------------------------------------------------------------------
// Each input item is one executed instruction (pc, next_pc); each produces
// exactly one result item with hit/right/allocate/collision flags and the
// five running counters after that instruction. For each item the entry is
// read from the single table memory in the accept cycle and, on a hit or a
// taken miss, written back in the next, or later while the output register
// still holds an unread result. The block takes a new item once that
// write-back is done, even while the previous result still waits in the
// output register. After reset the block clears the valid marks with one
// memory write per cycle, so input is held off until all TABLE_ENTRIES entries
// (1024 by default) are cleared. TABLE_ENTRIES must be a power of two; the table index
// is pc bits starting at bit 10.
// ----------------------------------------------------------------------------
module branch_target_buffer_predictor #(
    parameter int TABLE_ENTRIES = btbp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // tdata: pc[31:0], next_pc[63:32]
    input  logic [btbp_pkg::IN_W-1:0]  i_s_tdata,
    // result item
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // tdata: lookup_hit[0], prediction_right[1], allocated[2], collided[3],
    //        hit_total[35:4], miss_total[67:36], right_total[99:68],
    //        wrong_total[131:100], collision_total[163:132], zero[167:164]
    output logic [btbp_pkg::OUT_W-1:0] o_m_tdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } t_state;

    t_state                      r_state;
    logic [IDX_W-1:0]            r_clr_idx;
    logic [btbp_pkg::ADDR_W-1:0] r_pc;
    logic [btbp_pkg::ADDR_W-1:0] r_next_pc;
    logic [btbp_pkg::ADDR_W-1:0] r_hit_cnt;
    logic [btbp_pkg::ADDR_W-1:0] r_miss_cnt;
    logic [btbp_pkg::ADDR_W-1:0] r_right_cnt;
    logic [btbp_pkg::ADDR_W-1:0] r_wrong_cnt;
    logic [btbp_pkg::ADDR_W-1:0] r_coll_cnt;
    logic                        r_m_valid;
    logic [btbp_pkg::OUT_W-1:0]  r_m_data;

    logic [btbp_pkg::ADDR_W-1:0] n_hit_cnt;
    logic [btbp_pkg::ADDR_W-1:0] n_miss_cnt;
    logic [btbp_pkg::ADDR_W-1:0] n_right_cnt;
    logic [btbp_pkg::ADDR_W-1:0] n_wrong_cnt;
    logic [btbp_pkg::ADDR_W-1:0] n_coll_cnt;

    logic                        s_accept;
    logic                        out_free;
    logic                        done;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    btbp_pkg::t_entry            wr_data;
    btbp_pkg::t_entry            rd_entry;
    btbp_pkg::t_entry            upd_entry;
    btbp_pkg::t_upd              upd;

    // handshake
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;
    assign done       = (r_state == ST_EVAL) && out_free;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // memory access: read on accept, clear sweep or write back otherwise
    assign rd_en   = s_accept;
    assign rd_addr = i_s_tdata[btbp_pkg::INDEX_SHIFT +: IDX_W];
    assign wr_en   = (r_state == ST_CLEAR) || (done && upd.wr_en);
    assign wr_addr = (r_state == ST_CLEAR) ? r_clr_idx
                                           : r_pc[btbp_pkg::INDEX_SHIFT +: IDX_W];
    assign wr_data = (r_state == ST_CLEAR) ? btbp_pkg::t_entry'('0) : upd_entry;

    btbp_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    btbp_update u_update (
        .i_pc      (r_pc),
        .i_next_pc (r_next_pc),
        .i_entry   (rd_entry),
        .o_entry   (upd_entry),
        .o_upd     (upd)
    );

    // counters after this item
    always_comb begin
        n_hit_cnt   = r_hit_cnt   + {31'd0, upd.hit};
        n_miss_cnt  = r_miss_cnt  + {31'd0, upd.alloc};
        n_right_cnt = r_right_cnt + {31'd0, upd.hit && upd.right};
        n_wrong_cnt = r_wrong_cnt + {31'd0, upd.hit && !upd.right};
        n_coll_cnt  = r_coll_cnt  + {31'd0, upd.coll};
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_pc      <= i_s_tdata[31:0];
            r_next_pc <= i_s_tdata[63:32];
        end
        if (done) begin
            r_m_data <= {4'd0, n_coll_cnt, n_wrong_cnt, n_right_cnt,
                         n_miss_cnt, n_hit_cnt,
                         upd.coll, upd.alloc, upd.right, upd.hit};
        end
    end

    // sequencer, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_right_cnt <= '0;
            r_wrong_cnt <= '0;
            r_coll_cnt  <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            // result register fills on done, empties when taken
            if (done) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (out_free) begin
                        r_hit_cnt   <= n_hit_cnt;
                        r_miss_cnt  <= n_miss_cnt;
                        r_right_cnt <= n_right_cnt;
                        r_wrong_cnt <= n_wrong_cnt;
                        r_coll_cnt  <= n_coll_cnt;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> bench/branch_target_buffer_predictor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_target_buffer_predictor_tb
// Self-checking bench for the branch target buffer predictor. A short table
// of directed branches walks every direction state, target retrain, address
// wrap and table collision; then random fetch streams drawn from a small pool
// of hot branches (plus noise) are checked against a behavioral model of the
// table. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module branch_target_buffer_predictor_tb;

    localparam int DEPTH        = btbp_pkg::TABLE_ENTRIES_DEF;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    localparam int N_DIRECTED   = 21;
    localparam int RANDOM_ITEMS = 1350;
    localparam int POOL_SIZE    = 16;
    localparam int HOT_SETS     = 12;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // result item as packed on o_m_tdata, top field first
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] collision_total;
        logic [31:0] wrong_total;
        logic [31:0] right_total;
        logic [31:0] miss_total;
        logic [31:0] hit_total;
        logic        collided;
        logic        allocated;
        logic        prediction_right;
        logic        lookup_hit;
    } t_btb_result;

    // one executed instruction, with an optional hand-written expectation
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] next_pc;
        logic        typed;
        t_btb_result fixed;
    } t_branch_item;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    // tdata: pc[31:0], next_pc[63:32]
    logic [btbp_pkg::IN_W-1:0]     i_s_tdata  = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    // tdata: lookup_hit, prediction_right, allocated, collided, hit_total,
    //        miss_total, right_total, wrong_total, collision_total, zero pad
    logic [btbp_pkg::OUT_W-1:0]    o_m_tdata;

    branch_target_buffer_predictor #(
        .TABLE_ENTRIES(DEPTH)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // shadow copy of the branch table and running counters
    bit          shadow_valid  [DEPTH];
    logic [31:0] shadow_tag    [DEPTH];
    logic [31:0] shadow_target [DEPTH];
    logic [1:0]  shadow_state  [DEPTH];
    logic [31:0] n_hit   = '0;
    logic [31:0] n_miss  = '0;
    logic [31:0] n_right = '0;
    logic [31:0] n_wrong = '0;
    logic [31:0] n_coll  = '0;

    t_branch_item dir_tab [N_DIRECTED];
    t_branch_item branch_q[$];
    t_branch_item cur_branch;
    t_btb_result  outcome_q[$];
    int           n_accepted = 0;
    int           n_results  = 0;
    int           errors     = 0;
    int           burst_left = 0;
    int           gap_left   = 0;
    t_rx_mode     rx_mode    = RX_OPEN;
    int           mode_left  = 0;
    int unsigned  rx_tick    = 0;
    int unsigned  cycle_count = 0;

    // look up, score and train the shadow table for one instruction
    function automatic t_btb_result score_branch(input logic [31:0] pc,
                                                 input logic [31:0] next_pc);
        logic [IDX_W-1:0] idx;
        logic             taken;
        logic [1:0]       st;
        t_btb_result      r;
        idx   = pc[btbp_pkg::INDEX_SHIFT +: IDX_W];
        taken = (next_pc != pc + btbp_pkg::INSN_BYTES);
        r     = '0;
        r.lookup_hit = shadow_valid[idx] && (shadow_tag[idx] == pc);
        if (r.lookup_hit) begin
            st = shadow_state[idx];
            n_hit++;
            if (taken) begin
                if (st == btbp_pkg::PRED_STRONG_TAKEN ||
                    st == btbp_pkg::PRED_WEAK_TAKEN) begin
                    // right direction, target decides
                    if (shadow_target[idx] == next_pc) begin
                        r.prediction_right = 1'b1;
                        st = btbp_pkg::PRED_STRONG_TAKEN;
                    end else begin
                        shadow_target[idx] = next_pc;
                    end
                end else if (st == btbp_pkg::PRED_STRONG_NOT_TAKEN) begin
                    st = btbp_pkg::PRED_WEAK_NOT_TAKEN;
                end else begin
                    st = btbp_pkg::PRED_WEAK_TAKEN;
                end
            end else begin
                case (st)
                    btbp_pkg::PRED_STRONG_TAKEN: st = btbp_pkg::PRED_WEAK_TAKEN;
                    btbp_pkg::PRED_WEAK_TAKEN:   st = btbp_pkg::PRED_WEAK_NOT_TAKEN;
                    default: begin
                        r.prediction_right = 1'b1;
                        st = btbp_pkg::PRED_STRONG_NOT_TAKEN;
                    end
                endcase
            end
            shadow_state[idx] = st;
            if (r.prediction_right) n_right++;
            else n_wrong++;
        end else if (taken) begin
            // taken miss allocates as strongly taken
            r.allocated = 1'b1;
            n_miss++;
            if (shadow_valid[idx]) begin
                r.collided = 1'b1;
                n_coll++;
            end
            shadow_valid[idx]  = 1'b1;
            shadow_tag[idx]    = pc;
            shadow_target[idx] = next_pc;
            shadow_state[idx]  = btbp_pkg::PRED_STRONG_TAKEN;
        end
        r.hit_total       = n_hit;
        r.miss_total      = n_miss;
        r.right_total     = n_right;
        r.wrong_total     = n_wrong;
        r.collision_total = n_coll;
        return r;
    endfunction

    // random fetch streams: mostly hot branches, some noise
    task automatic gen_random_branches();
        logic [31:0]      pool_pc  [POOL_SIZE];
        logic [31:0]      pool_tgt [POOL_SIZE][2];
        logic [IDX_W-1:0] hot_idx  [HOT_SETS];
        logic [31:0]      pc;
        logic [31:0]      nxt;
        int               slot;
        int               roll;
        t_branch_item     it;
        hot_idx[0] = '0;
        hot_idx[1] = '1;
        for (int k = 2; k < HOT_SETS; k++) hot_idx[k] = IDX_W'($urandom);
        for (int s = 0; s < POOL_SIZE; s++) begin
            pool_pc[s] = $urandom;
            pool_pc[s][btbp_pkg::INDEX_SHIFT +: IDX_W] =
                hot_idx[$urandom_range(0, HOT_SETS - 1)];
            pool_tgt[s][0] = $urandom;
            pool_tgt[s][1] = $urandom;
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            slot = $urandom_range(0, POOL_SIZE - 1);
            // now and then a hot branch is replaced by a new one
            if (roll < 4) begin
                pool_pc[slot] = $urandom;
                pool_pc[slot][btbp_pkg::INDEX_SHIFT +: IDX_W] =
                    hot_idx[$urandom_range(0, HOT_SETS - 1)];
                pool_tgt[slot][0] = $urandom;
                pool_tgt[slot][1] = $urandom;
            end
            if (roll < 85) begin
                pc   = pool_pc[slot];
                roll = $urandom_range(0, 99);
                if (roll < 35) nxt = pc + btbp_pkg::INSN_BYTES;
                else if (roll < 80) nxt = pool_tgt[slot][0];
                else nxt = pool_tgt[slot][1];
            end else begin
                pc  = $urandom;
                nxt = $urandom_range(0, 1) ? pc + btbp_pkg::INSN_BYTES : 32'($urandom);
            end
            it = '0;
            it.pc      = pc;
            it.next_pc = nxt;
            branch_q.push_back(it);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // sender: bursts of items with random gaps
    always @(posedge i_clk) begin
        t_btb_result predicted;
        logic        take_next;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            take_next = !i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                predicted = score_branch(cur_branch.pc, cur_branch.next_pc);
                outcome_q.push_back(cur_branch.typed ? cur_branch.fixed : predicted);
                n_accepted++;
                take_next = 1'b1;
            end
            if (take_next) begin
                if (gap_left > 0 || branch_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_s_tvalid <= 1'b0;
                end else begin
                    cur_branch = branch_q.pop_front();
                    i_s_tdata  <= {cur_branch.next_pc, cur_branch.pc};
                    i_s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(64, 160);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(1, 6);
                        end
                    end
                end
            end
        end
    end

    // receiver: picks a new stall pattern whenever the current one runs out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 200);
            end else begin
                mode_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:     i_m_tready <= 1'b1;
                RX_RANDOM:   i_m_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: i_m_tready <= ((rx_tick % 5) < 2);
                default:     i_m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        t_btb_result got;
        t_btb_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            n_results++;
            if (outcome_q.size() == 0) begin
                errors++;
                $display("%0t: result item with nothing expected, expected none actual %h",
                         $time, got);
            end else begin
                want = outcome_q.pop_front();
                check_field("lookup_hit",       want.lookup_hit,       got.lookup_hit);
                check_field("prediction_right", want.prediction_right, got.prediction_right);
                check_field("allocated",        want.allocated,        got.allocated);
                check_field("collided",         want.collided,         got.collided);
                check_field("hit_total",        want.hit_total,        got.hit_total);
                check_field("miss_total",       want.miss_total,       got.miss_total);
                check_field("right_total",      want.right_total,      got.right_total);
                check_field("wrong_total",      want.wrong_total,      got.wrong_total);
                check_field("collision_total",  want.collision_total,  got.collision_total);
                check_field("pad",              want.pad,              got.pad);
            end
        end
    end

    // run limit, covers the clearing pass after reset
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d items accepted, %0d results outstanding",
                     $time, n_accepted, outcome_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int total;
        // directed branches; index 0 and the top index are the table extremes
        dir_tab[0]  = '{32'h0000_0000, 32'h0000_0004, 1'b1, '0};
        dir_tab[1]  = '{32'h0000_0000, 32'h0000_0000, 1'b1,
                        t_btb_result'{allocated: 1'b1, miss_total: 32'd1, default: '0}};
        dir_tab[2]  = '{32'h0000_0000, 32'h0000_0000, 1'b1,
                        t_btb_result'{lookup_hit: 1'b1, prediction_right: 1'b1,
                                      hit_total: 32'd1, miss_total: 32'd1,
                                      right_total: 32'd1, default: '0}};
        // walk the direction states down with fall-through, then back up
        dir_tab[3]  = '{32'h0000_0000, 32'h0000_0004, 1'b0, '0};
        dir_tab[4]  = '{32'h0000_0000, 32'h0000_0004, 1'b0, '0};
        dir_tab[5]  = '{32'h0000_0000, 32'h0000_0004, 1'b0, '0};
        dir_tab[6]  = '{32'h0000_0000, 32'h0000_0004, 1'b0, '0};
        dir_tab[7]  = '{32'h0000_0000, 32'h0000_0100, 1'b0, '0};
        dir_tab[8]  = '{32'h0000_0000, 32'h0000_0100, 1'b0, '0};
        // predicted taken but the target moved
        dir_tab[9]  = '{32'h0000_0000, 32'h0000_0200, 1'b0, '0};
        dir_tab[10] = '{32'h0000_0000, 32'h0000_0200, 1'b0, '0};
        // same set, different tag: collision, then the old branch collides back
        dir_tab[11] = '{32'h0010_0000, 32'h0000_0000, 1'b0, '0};
        dir_tab[12] = '{32'h0000_0000, 32'h0000_0200, 1'b0, '0};
        // fall-through across the top of the address space is not taken
        dir_tab[13] = '{32'hFFFF_FFFF, 32'h0000_0003, 1'b0, '0};
        dir_tab[14] = '{32'hFFFF_FFFC, 32'h0000_0000, 1'b0, '0};
        dir_tab[15] = '{32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, '0};
        dir_tab[16] = '{32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, '0};
        dir_tab[17] = '{32'hFFFF_FFFC, 32'h0000_0000, 1'b0, '0};
        dir_tab[18] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0};
        dir_tab[19] = '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0};
        dir_tab[20] = '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0};
        for (int k = 0; k < N_DIRECTED; k++) branch_q.push_back(dir_tab[k]);
        gen_random_branches();
        total = branch_q.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < total) @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d branches, %0d results: %0d hits (%0d right, %0d wrong)",
                 n_accepted, n_results, n_hit, n_right, n_wrong);
        $display("allocations %0d, collisions %0d, mismatches %0d",
                 n_miss, n_coll, errors);
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
